/* hdl/traffic_light_with_walk_request_assert.svh */
// ----------------------------------------------------------------------------
// Traffic light assertion macros
// Shorthand for the concurrent checks of the traffic light controller.
// ----------------------------------------------------------------------------
`ifndef TRAFFIC_LIGHT_WITH_WALK_REQUEST_ASSERT_SVH
`define TRAFFIC_LIGHT_WITH_WALK_REQUEST_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define TLWR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define TLWR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tlwr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Traffic light package
// Shared types, constants and the seven-segment table.
// ----------------------------------------------------------------------------
package tlwr_pkg;

  // Tick counter width and the wider of it and the length registers
  localparam int COUNT_WIDTH = 8;
  localparam int LEN_WIDTH   = 8;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > LEN_WIDTH) ? COUNT_WIDTH : LEN_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Countdown and register widths
  localparam int CD_WIDTH  = 7;
  localparam int RED_WIDTH = 7;
  localparam int SEG_WIDTH = 8;
  localparam logic [CD_WIDTH-1:0] CD_LIMIT = 7'd99;

  // Register reset values
  localparam logic [LEN_WIDTH-1:0] GREEN_RESET  = 8'd30;
  localparam logic [LEN_WIDTH-1:0] YELLOW_RESET = 8'd3;
  localparam logic [RED_WIDTH-1:0] RED_RESET    = 7'd20;

  // Vehicle phase, one-hot
  typedef enum logic [2:0] {
    PH_GREEN  = 3'b001,
    PH_YELLOW = 3'b010,
    PH_RED    = 3'b100
  } phase_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_GREEN  = 2'd0,
    CFG_YELLOW = 2'd1,
    CFG_RED    = 2'd2
  } cfg_idx_t;

  // Countdown display request into the digit decoder
  typedef struct packed {
    logic                shown;
    logic [CD_WIDTH-1:0] value;
  } disp_req_t;

  // Segment pattern a..g,dp with a in bit 7
  function automatic logic [SEG_WIDTH-1:0] seg_pattern(input logic [3:0] digit);
    logic [SEG_WIDTH-1:0] pat;
    case (digit)
      4'd0:    pat = 8'hFC;
      4'd1:    pat = 8'h60;
      4'd2:    pat = 8'hDA;
      4'd3:    pat = 8'hF2;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'hB6;
      4'd6:    pat = 8'hBE;
      4'd7:    pat = 8'hE0;
      4'd8:    pat = 8'hFE;
      4'd9:    pat = 8'hF6;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage
`default_nettype wire

/* hdl/traffic_light_with_walk_request.sv */
`timescale 1ns / 1ps
`default_nettype none
// Traffic light controller with pedestrian walk request. Takes one input beat
// per clock and returns one result beat for each, in the cycle after acceptance;
// the whole phase, counter, countdown and latch update is a single registered
// stage, so the sustained rate is one beat per cycle whenever the output side
// is ready. A result that waits at the output holds the input off only while
// the result register is full and not being taken. Configuration writes are
// always accepted and take effect for the next input beat.
// ----------------------------------------------------------------------------
// Traffic light with walk request, top level
// Vehicle phase sequencer, walk lamp, countdown and result register.
// ----------------------------------------------------------------------------
`include "traffic_light_with_walk_request_assert.svh"

module traffic_light_with_walk_request (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // input beats
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_tick,
  input  logic       in_button,
  // result beats
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_vehicle_red,
  output logic       out_vehicle_yellow,
  output logic       out_vehicle_green,
  output logic       out_walk_red,
  output logic       out_walk_green,
  output logic       out_display_on,
  output logic [tlwr_pkg::CD_WIDTH-1:0]  out_countdown_value,
  output logic [tlwr_pkg::SEG_WIDTH-1:0] out_tens_segments,
  output logic [tlwr_pkg::SEG_WIDTH-1:0] out_ones_segments
);
  import tlwr_pkg::*;

  // Configuration registers
  logic [LEN_WIDTH-1:0]   green_ticks_r;
  logic [LEN_WIDTH-1:0]   yellow_ticks_r;
  logic [RED_WIDTH-1:0]   red_ticks_r;

  // Controller state
  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] tick_count_r, tick_count_nxt;
  logic [CD_WIDTH-1:0]    countdown_r, countdown_nxt;
  logic                   request_used_r, request_used_nxt;
  logic                   walk_is_green_r, walk_is_green_nxt;
  logic [CD_WIDTH-1:0]    reload_val;

  // Result register
  logic                   out_valid_r;
  logic                   veh_red_r, veh_yellow_r, veh_green_r;
  logic                   walk_green_r;
  logic                   display_on_r;
  logic [CD_WIDTH-1:0]    countdown_out_r;
  logic [SEG_WIDTH-1:0]   tens_seg_r, ones_seg_r;

  logic                   in_accept;
  disp_req_t              disp_req;
  logic [SEG_WIDTH-1:0]   tens_seg, ones_seg;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  // Write configuration registers, drop unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      green_ticks_r  <= GREEN_RESET;
      yellow_ticks_r <= YELLOW_RESET;
      red_ticks_r    <= RED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GREEN:  green_ticks_r  <= cfg_data;
        CFG_YELLOW: yellow_ticks_r <= cfg_data;
        CFG_RED:    red_ticks_r    <= cfg_data[RED_WIDTH-1:0];
        default:    ;
      endcase
    end
  end

  // Limit the countdown reload to two digits
  assign reload_val = (red_ticks_r > CD_LIMIT) ? CD_LIMIT : red_ticks_r;

  // Advance the phase sequencer for one beat
  always_comb begin
    phase_nxt         = phase_r;
    tick_count_nxt    = tick_count_r;
    countdown_nxt     = countdown_r;
    request_used_nxt  = request_used_r;
    walk_is_green_nxt = walk_is_green_r;

    if (in_tick) begin
      if (tick_count_nxt != COUNT_MAX) begin
        tick_count_nxt = tick_count_nxt + COUNT_WIDTH'(1);
      end
      if (phase_nxt == PH_RED && countdown_nxt != '0) begin
        countdown_nxt = countdown_nxt - CD_WIDTH'(1);
      end
      if (phase_nxt == PH_GREEN &&
          CMP_WIDTH'(tick_count_nxt) >= CMP_WIDTH'(green_ticks_r)) begin
        phase_nxt      = PH_YELLOW;
        tick_count_nxt = '0;
      end
      if (phase_nxt == PH_YELLOW &&
          CMP_WIDTH'(tick_count_nxt) >= CMP_WIDTH'(yellow_ticks_r)) begin
        phase_nxt      = PH_RED;
        tick_count_nxt = '0;
      end
      if (phase_nxt == PH_RED &&
          CMP_WIDTH'(tick_count_nxt) >= CMP_WIDTH'(red_ticks_r)) begin
        phase_nxt        = PH_GREEN;
        countdown_nxt    = reload_val;
        request_used_nxt = 1'b0;
        tick_count_nxt   = '0;
      end
    end

    // Pedestrian request cuts the phase short once per light cycle
    if (in_button && !request_used_nxt) begin
      phase_nxt        = PH_YELLOW;
      request_used_nxt = 1'b1;
      tick_count_nxt   = '0;
    end

    // Walk lamp follows the phase, yellow holds it
    if (phase_nxt == PH_GREEN) begin
      walk_is_green_nxt = 1'b0;
    end else if (phase_nxt == PH_RED) begin
      walk_is_green_nxt = 1'b1;
    end
  end

  // Update state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_GREEN;
      tick_count_r    <= '0;
      countdown_r     <= CD_WIDTH'(RED_RESET);
      request_used_r  <= 1'b0;
      walk_is_green_r <= 1'b0;
    end else if (in_accept) begin
      phase_r         <= phase_nxt;
      tick_count_r    <= tick_count_nxt;
      countdown_r     <= countdown_nxt;
      request_used_r  <= request_used_nxt;
      walk_is_green_r <= walk_is_green_nxt;
    end
  end

  // Decode the countdown digits from the updated state
  assign disp_req.shown = (phase_nxt != PH_GREEN);
  assign disp_req.value = countdown_nxt;

  tlwr_digits u_digits (
    .req      (disp_req),
    .tens_seg (tens_seg),
    .ones_seg (ones_seg)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      veh_red_r       <= (phase_nxt == PH_RED);
      veh_yellow_r    <= (phase_nxt == PH_YELLOW);
      veh_green_r     <= (phase_nxt == PH_GREEN);
      walk_green_r    <= walk_is_green_nxt;
      display_on_r    <= disp_req.shown;
      countdown_out_r <= countdown_nxt;
      tens_seg_r      <= tens_seg;
      ones_seg_r      <= ones_seg;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_vehicle_red     = veh_red_r;
  assign out_vehicle_yellow  = veh_yellow_r;
  assign out_vehicle_green   = veh_green_r;
  assign out_walk_red        = !walk_green_r;
  assign out_walk_green      = walk_green_r;
  assign out_display_on      = display_on_r;
  assign out_countdown_value = countdown_out_r;
  assign out_tens_segments   = tens_seg_r;
  assign out_ones_segments   = ones_seg_r;

  // Checks
  `TLWR_ASSERT_NOW(a_one_lamp, out_valid_r,
    $onehot({veh_red_r, veh_yellow_r, veh_green_r}), "vehicle lamps not exactly one")
  `TLWR_ASSERT_NOW(a_walk_not_green, walk_is_green_r,
    phase_r != PH_GREEN, "walk green during vehicle green")
  `TLWR_ASSERT_NOW(a_countdown_range, 1'b1,
    countdown_r <= CD_LIMIT, "countdown above two digits")
  `TLWR_ASSERT_NEXT(a_accept_result, in_accept,
    out_valid_r, "accepted beat produced no result")

endmodule
`default_nettype wire

/* hdl/tlwr_digits.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Countdown digit decoder
// Splits the countdown (0..99) into tens and ones and maps them to segments.
// ----------------------------------------------------------------------------
module tlwr_digits (
  input  var tlwr_pkg::disp_req_t                 req,
  output logic [tlwr_pkg::SEG_WIDTH-1:0]          tens_seg,
  output logic [tlwr_pkg::SEG_WIDTH-1:0]          ones_seg
);
  import tlwr_pkg::*;

  logic [14:0]          recip_prod;
  logic [3:0]           tens;
  logic [CD_WIDTH-1:0]  tens_x10;
  logic [CD_WIDTH-1:0]  ones_full;
  logic [3:0]           ones;

  // Divide by ten via reciprocal 205/2048, exact for 0..99
  assign recip_prod = 15'(req.value) * 15'd205;
  assign tens       = recip_prod[14:11];
  assign tens_x10   = CD_WIDTH'({tens, 3'b000}) + CD_WIDTH'({tens, 1'b0});
  assign ones_full  = req.value - tens_x10;
  assign ones       = ones_full[3:0];

  // Blank both digits while green
  assign tens_seg = req.shown ? seg_pattern(tens) : '0;
  assign ones_seg = req.shown ? seg_pattern(ones) : '0;

endmodule
`default_nettype wire

/* bench/tb_traffic_light_with_walk_request.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traffic light with walk request testbench
// Drives tick/button beats through the controller under several length
// settings, including zero, maximal and above-99 red lengths. A scoreboard
// predicts the lamps, countdown and digit patterns for every accepted beat
// and checks each result beat in order against that prediction.
// ----------------------------------------------------------------------------

typedef struct {
  bit       vehicle_red;
  bit       vehicle_yellow;
  bit       vehicle_green;
  bit       walk_red;
  bit       walk_green;
  bit       display_on;
  bit [6:0] countdown_value;
  bit [7:0] tens_segments;
  bit [7:0] ones_segments;
} lamp_beat_t;

class lamp_predictor;
  // length registers
  bit [7:0] green_len;
  bit [7:0] yellow_len;
  bit [6:0] red_len;

  // controller state
  tlwr_pkg::phase_t phase;
  bit [tlwr_pkg::COUNT_WIDTH-1:0] tick_count;
  bit [6:0] countdown;
  bit request_used;
  bit walk_green;

  lamp_beat_t pending_lamps[$];
  int mismatches;

  bit [7:0] digit_seg[10] = '{8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66,
                              8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6};

  function new();
    green_len    = tlwr_pkg::GREEN_RESET;
    yellow_len   = tlwr_pkg::YELLOW_RESET;
    red_len      = tlwr_pkg::RED_RESET;
    phase        = tlwr_pkg::PH_GREEN;
    tick_count   = '0;
    countdown    = tlwr_pkg::RED_RESET;
    request_used = 1'b0;
    walk_green   = 1'b0;
    mismatches   = 0;
  endfunction

  // Update a length register; unknown indexes are dropped
  function void write_reg(bit [1:0] idx, bit [7:0] data);
    case (idx)
      tlwr_pkg::CFG_GREEN:  green_len  = data;
      tlwr_pkg::CFG_YELLOW: yellow_len = data;
      tlwr_pkg::CFG_RED:    red_len    = data[6:0];
      default: ;
    endcase
  endfunction

  // Advance the controller by one accepted beat and queue its result
  function void take_request(bit tick, bit button);
    lamp_beat_t exp_beat;
    bit shown;
    if (tick) begin
      if (tick_count != tlwr_pkg::COUNT_MAX) tick_count++;
      if (phase == tlwr_pkg::PH_RED && countdown != 0) countdown--;
      if (phase == tlwr_pkg::PH_GREEN && tick_count >= green_len) begin
        phase = tlwr_pkg::PH_YELLOW;
        tick_count = '0;
      end
      if (phase == tlwr_pkg::PH_YELLOW && tick_count >= yellow_len) begin
        phase = tlwr_pkg::PH_RED;
        tick_count = '0;
      end
      if (phase == tlwr_pkg::PH_RED && tick_count >= red_len) begin
        phase = tlwr_pkg::PH_GREEN;
        countdown = (red_len > 7'd99) ? 7'd99 : red_len;
        request_used = 1'b0;
        tick_count = '0;
      end
    end

    // a fresh button press cuts the phase short
    if (button && !request_used) begin
      phase = tlwr_pkg::PH_YELLOW;
      request_used = 1'b1;
      tick_count = '0;
    end

    // walk lamp holds through yellow
    if (phase == tlwr_pkg::PH_GREEN) walk_green = 1'b0;
    else if (phase == tlwr_pkg::PH_RED) walk_green = 1'b1;

    shown = (phase != tlwr_pkg::PH_GREEN);
    exp_beat.vehicle_red     = (phase == tlwr_pkg::PH_RED);
    exp_beat.vehicle_yellow  = (phase == tlwr_pkg::PH_YELLOW);
    exp_beat.vehicle_green   = (phase == tlwr_pkg::PH_GREEN);
    exp_beat.walk_red        = !walk_green;
    exp_beat.walk_green      = walk_green;
    exp_beat.display_on      = shown;
    exp_beat.countdown_value = countdown;
    exp_beat.tens_segments   = shown ? digit_seg[(countdown / 10) % 10] : 8'h00;
    exp_beat.ones_segments   = shown ? digit_seg[countdown % 10] : 8'h00;
    pending_lamps.push_back(exp_beat);
  endfunction

  function void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      mismatches++;
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endfunction

  // Compare a result beat with the oldest prediction
  function void compare_lamps(lamp_beat_t got);
    lamp_beat_t exp_beat;
    if (pending_lamps.size() == 0) begin
      mismatches++;
      $display("%0t result beat with no prediction waiting", $time);
      return;
    end
    exp_beat = pending_lamps.pop_front();
    check_field("vehicle_red", int'(exp_beat.vehicle_red), int'(got.vehicle_red));
    check_field("vehicle_yellow", int'(exp_beat.vehicle_yellow),
                int'(got.vehicle_yellow));
    check_field("vehicle_green", int'(exp_beat.vehicle_green), int'(got.vehicle_green));
    check_field("walk_red", int'(exp_beat.walk_red), int'(got.walk_red));
    check_field("walk_green", int'(exp_beat.walk_green), int'(got.walk_green));
    check_field("display_on", int'(exp_beat.display_on), int'(got.display_on));
    check_field("countdown_value", int'(exp_beat.countdown_value),
                int'(got.countdown_value));
    check_field("tens_segments", int'(exp_beat.tens_segments), int'(got.tens_segments));
    check_field("ones_segments", int'(exp_beat.ones_segments), int'(got.ones_segments));
  endfunction
endclass

module tb_traffic_light_with_walk_request;
  import tlwr_pkg::*;

  localparam logic [1:0] CFG_NONE    = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         HOLD_CYCLES = 80;
  localparam int         PHASE_BEATS = 110;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic in_tick;
  logic in_button;
  logic out_valid;
  logic out_ready;
  logic out_vehicle_red;
  logic out_vehicle_yellow;
  logic out_vehicle_green;
  logic out_walk_red;
  logic out_walk_green;
  logic out_display_on;
  logic [CD_WIDTH-1:0]  out_countdown_value;
  logic [SEG_WIDTH-1:0] out_tens_segments;
  logic [SEG_WIDTH-1:0] out_ones_segments;

  lamp_predictor model = new();

  int  next_gap = 1;
  int  press_left = 0;
  int  cycles = 0;
  bit  busy_mode = 1'b0;
  bit  hold_request = 1'b0;

  traffic_light_with_walk_request dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_tick            (in_tick),
    .in_button          (in_button),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_vehicle_red    (out_vehicle_red),
    .out_vehicle_yellow (out_vehicle_yellow),
    .out_vehicle_green  (out_vehicle_green),
    .out_walk_red       (out_walk_red),
    .out_walk_green     (out_walk_green),
    .out_display_on     (out_display_on),
    .out_countdown_value(out_countdown_value),
    .out_tens_segments  (out_tens_segments),
    .out_ones_segments  (out_ones_segments)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int idle_draw();
    return busy_mode ? 0 : $urandom_range(0, 19);
  endfunction

  // Offer one beat, hold it until accepted, then idle for the next draw
  task automatic send_item(bit tick, bit button);
    in_valid  <= 1'b1;
    in_tick   <= tick;
    in_button <= button;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model.take_request(tick, button);
    next_gap = idle_draw();
    if (next_gap > 0) begin
      in_valid <= 1'b0;
      repeat (next_gap) @(posedge clk);
    end
  endtask

  // Send n beats packed as {tick, button} pairs, oldest in the top bits
  task automatic send_pattern(bit [31:0] pat, int n);
    for (int i = n - 1; i >= 0; i--) send_item(pat[2*i+1], pat[2*i]);
  endtask

  // Mostly ticks with short button holds, some plain noise
  task automatic send_random_item();
    bit tick;
    bit button;
    if ($urandom_range(0, 9) < 8) begin
      tick = ($urandom_range(0, 4) != 0);
      if (press_left > 0) begin
        button = 1'b1;
        press_left--;
      end else if ($urandom_range(0, 19) == 0) begin
        button = 1'b1;
        press_left = $urandom_range(0, 5);
      end else begin
        button = 1'b0;
      end
    end else begin
      tick   = 1'($urandom_range(0, 1));
      button = 1'($urandom_range(0, 1));
    end
    send_item(tick, button);
  endtask

  // Drop valid and wait until every predicted beat has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (model.pending_lamps.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_lengths(logic [7:0] g, logic [7:0] y, logic [7:0] r);
    write_reg(CFG_GREEN, g);
    write_reg(CFG_YELLOW, y);
    write_reg(CFG_RED, r);
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    lamp_beat_t got;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = idle_draw();
      if (hold_request) begin
        hold_request = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.vehicle_red     = out_vehicle_red;
      got.vehicle_yellow  = out_vehicle_yellow;
      got.vehicle_green   = out_vehicle_green;
      got.walk_red        = out_walk_red;
      got.walk_green      = out_walk_green;
      got.display_on      = out_display_on;
      got.countdown_value = out_countdown_value;
      got.tens_segments   = out_tens_segments;
      got.ones_segments   = out_ones_segments;
      model.compare_lamps(got);
    end
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [7:0] g;
    logic [7:0] y;
    logic [7:0] r;
    in_valid  <= 1'b0;
    in_tick   <= 1'b0;
    in_button <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_GREEN;
    cfg_data  <= 8'h00;
    rst_n     <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset lengths: press, held button, yellow run-out into red
    send_pattern(32'h00276A8E, 12);
    drain();

    // short lengths: full cycle, then a press during green
    write_lengths(8'd1, 8'd1, 8'd2);
    send_pattern(32'h0000AABA, 8);
    drain();

    // zero lengths pass every phase in one tick; stray index is dropped
    write_lengths(8'd0, 8'd0, 8'd0);
    write_reg(CFG_NONE, 8'h05);
    send_pattern(32'h0000026E, 5);
    drain();

    // random traffic under a range of length settings
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin g = 8'd30;  y = 8'd3;   r = 8'd20;  end
        1: begin g = 8'd0;   y = 8'd0;   r = 8'd0;   end
        2: begin g = 8'd255; y = 8'd255; r = 8'hE3;  end
        3: begin g = 8'd1;   y = 8'd1;   r = 8'd1;   end
        4: begin g = 8'd2;   y = 8'd1;   r = 8'hFF;  end
        5: begin g = 8'd4;   y = 8'd2;   r = 8'h64;  end
        6: begin g = 8'd255; y = 8'd1;   r = 8'h80;  end
        default: begin
          g = 8'($urandom_range(0, 12));
          y = 8'($urandom_range(0, 6));
          r = 8'($urandom_range(0, 255));
        end
      endcase
      write_lengths(g, y, r);
      busy_mode = (p == 3) || (p == 7);
      if (p == 3) hold_request = 1'b1;
      press_left = 0;
      repeat (PHASE_BEATS) send_random_item();
      drain();
    end
    busy_mode = 1'b0;

    repeat (4) @(posedge clk);
    if (model.mismatches == 0 && model.pending_lamps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* traffic_light_with_walk_request.f */
+incdir+hdl
hdl/tlwr_pkg.sv
hdl/tlwr_digits.sv
hdl/traffic_light_with_walk_request.sv
bench/tb_traffic_light_with_walk_request.sv
